[rtl/core/b2s_pkg.sv]
// ----------------------------------------------------------------------------
// b2s_pkg: shared types and constants for the BLAKE2s hash engine
// Holds the IV, sigma schedule, sequencer state type and register indexes.
// ----------------------------------------------------------------------------
package b2s_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_DIGEST_LEN = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LEN    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_WORD0  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_WORD1  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_WORD2  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_WORD3  = 3'd5;

   localparam logic [31:0] PARAM_BASE = 32'h0101_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MIX,
      ST_FOLD,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] w;
      unique case (idx)
         3'd0: w = 32'h6A09E667;
         3'd1: w = 32'hBB67AE85;
         3'd2: w = 32'h3C6EF372;
         3'd3: w = 32'hA54FF53A;
         3'd4: w = 32'h510E527F;
         3'd5: w = 32'h9B05688C;
         3'd6: w = 32'h1F83D9AB;
         default: w = 32'h5BE0CD19;
      endcase
      return w;
   endfunction

   // message word index for round r, slot s (0..15)
   function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
      logic [63:0] row;
      unique case (r)
         4'd0: row = 64'hFEDCBA9876543210;
         4'd1: row = 64'h357B20C16DF984AE;
         4'd2: row = 64'h491763EADF250C8B;
         4'd3: row = 64'h8F04A562EBCD1397;
         4'd4: row = 64'hD386CB1EFA427509;
         4'd5: row = 64'h91EF57D438B0A6C2;
         4'd6: row = 64'hB8293670A4DEF15C;
         4'd7: row = 64'hA2684F05931CE7BD;
         4'd8: row = 64'h5A417D2C803B9EF6;
         default: row = 64'h0DC3E9BF5167482A;
      endcase
      return row[{s, 2'b00} +: 4];
   endfunction

endpackage

[rtl/core/blake2s_hash_engine.sv]
// ----------------------------------------------------------------------------
// blake2s_hash_engine: streaming BLAKE2s (RFC 7693) with optional key
// One message byte per request; finish emits digest_len bytes (clamped to 1..32), last marked.
// ----------------------------------------------------------------------------
// An absorbed byte goes straight into the block buffer unless it overflows a
// full block; then, as with a finish request, the block is compressed by one
// shared G half-step unit: 80 G calls of 2 half steps each, after a load step
// and before 8 fold steps. A finish is then followed by a response for each
// of the digest_len bytes (one byte per accepted response).
// A keyed message compresses its key block at the first absorb or finish.
// req_stall is high while compressing or emitting. The block buffer is a
// register array of 16 words written at message start, on absorb and when a
// finish pads the tail.
module blake2s_hash_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_digest_byte,
   output logic [4:0]                    rsp_byte_index,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic [b2s_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [b2s_pkg::CSR_DATA_W-1:0] csr_data
);
   import b2s_pkg::*;

   // configuration
   logic [5:0]  digest_len_ff, key_len_ff;
   logic [63:0] key_ff [4];

   // hash state
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [16];
   logic [31:0] m_ff [16];
   logic [63:0] count_ff;
   logic [6:0]  fill_ff;
   logic        fresh_ff;
   logic [5:0]  act_len_ff;
   state_type   state_ff, state_in;

   // sequencer
   logic [3:0]  round_ff;   // 0..9 while mixing
   logic [2:0]  gidx_ff;    // which G of the round
   logic        half_ff;    // first or second half of G
   logic [2:0]  fold_ff;
   logic        final_ff;   // compressing the last block
   logic        pend_ff;    // absorb byte waiting for a compression
   logic [7:0]  pend_byte_ff;
   logic [4:0]  out_ff;

   // clamped registers for message start
   logic [5:0] dl_c, kl_c;
   always_comb begin
      dl_c = (digest_len_ff == 6'd0) ? 6'd1 :
             (digest_len_ff > 6'd32) ? 6'd32 : digest_len_ff;
      kl_c = (key_len_ff > 6'd32) ? 6'd32 : key_len_ff;
   end

   wire req_acc = req_valid && !req_stall;
   wire rsp_acc = rsp_valid && !rsp_stall;

   // G column/diagonal lane indexes
   logic [3:0] ia, ib, ic, id;
   always_comb begin
      unique case (gidx_ff)
         3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
         3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
         3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
         3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
         3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
         3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
         3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
         default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
      endcase
   end

   // shared half-G unit: a+b+x, rotate d, c+d, rotate b
   logic [31:0] ga, gb, gc, gd, gx, t1, t2;
   logic [3:0]  slot;
   always_comb begin
      slot = {gidx_ff, half_ff};
      gx = m_ff[sigma(round_ff, slot)];
      ga = v_ff[ia] + v_ff[ib] + gx;
      t1 = v_ff[id] ^ ga;
      gd = half_ff ? {t1[7:0], t1[31:8]} : {t1[15:0], t1[31:16]};
      gc = v_ff[ic] + gd;
      t2 = v_ff[ib] ^ gc;
      gb = half_ff ? {t2[6:0], t2[31:7]} : {t2[11:0], t2[31:12]};
   end

   // word w of the zero-padded key block
   function automatic logic [31:0] key_block_word(input logic [3:0] w,
                                                  input logic [5:0] kl,
                                                  input logic [63:0] k0,
                                                  input logic [63:0] k1,
                                                  input logic [63:0] k2,
                                                  input logic [63:0] k3);
      logic [255:0] kv;
      logic [31:0]  r;
      logic [5:0]   bi;
      kv = {k3, k2, k1, k0};
      r  = 32'd0;
      for (int j = 0; j < 4; j++) begin
         bi = {1'b0, w[2:0], 2'(j)};
         if (w[3] == 1'b0 && bi < kl) r[8*j +: 8] = kv[8*bi +: 8];
      end
      return r;
   endfunction

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_acc) begin
               if (req_command) state_in = ST_LOAD;
               else if (fresh_ff ? (kl_c != 6'd0) : (fill_ff == 7'd64))
                  state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_MIX;
         ST_MIX:
            if (round_ff == 4'd9 && gidx_ff == 3'd7 && half_ff) state_in = ST_FOLD;
         ST_FOLD:
            if (fold_ff == 3'd7) state_in = final_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:
            if (rsp_acc && out_ff == 5'(act_len_ff - 6'd1)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digest_len_ff <= 6'd32;
         key_len_ff    <= 6'd0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DIGEST_LEN: digest_len_ff <= csr_data[5:0];
            CSR_KEY_LEN:    key_len_ff    <= csr_data[5:0];
            CSR_KEY_WORD0:  key_ff[0]     <= csr_data;
            CSR_KEY_WORD1:  key_ff[1]     <= csr_data;
            CSR_KEY_WORD2:  key_ff[2]     <= csr_data;
            CSR_KEY_WORD3:  key_ff[3]     <= csr_data;
            default: ;
         endcase
      end
   end

   // write position of an absorbed byte; a keyed start sees a full block
   logic [6:0] wpos;
   assign wpos = fresh_ff ? ((kl_c != 6'd0) ? 7'd64 : 7'd0) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff   <= 1'b1;
         fill_ff    <= 7'd0;
         count_ff   <= '0;
         act_len_ff <= 6'd32;
         pend_ff    <= 1'b0;
         final_ff   <= 1'b0;
         out_ff     <= '0;
         round_ff   <= '0;
         gidx_ff    <= '0;
         half_ff    <= 1'b0;
         fold_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_acc) begin
               if (fresh_ff) begin
                  for (int i = 0; i < 8; i++)
                     h_ff[i] <= iv_word(3'(i)) ^ ((i == 0) ?
                                (PARAM_BASE ^ {18'd0, kl_c, 8'd0} ^ {26'd0, dl_c}) :
                                32'd0);
                  for (int i = 0; i < 16; i++)
                     m_ff[i] <= key_block_word(4'(i), kl_c, key_ff[0], key_ff[1],
                                               key_ff[2], key_ff[3]);
                  act_len_ff <= dl_c;
                  count_ff   <= '0;
                  fresh_ff   <= 1'b0;
               end
               final_ff <= req_command;
               if (req_command) begin
                  // pad the tail of the block with zeros
                  for (int i = 0; i < 64; i++)
                     if (7'(i) >= wpos && !fresh_ff)
                        m_ff[i/4][8*(i%4) +: 8] <= 8'd0;
                  count_ff <= (fresh_ff ? 64'd0 : count_ff) + {57'd0, wpos};
                  fill_ff  <= 7'd64;
               end else if (wpos == 7'd64) begin
                  pend_ff      <= 1'b1;
                  pend_byte_ff <= req_data_byte;
                  count_ff     <= (fresh_ff ? 64'd0 : count_ff) + 64'd64;
               end else begin
                  m_ff[wpos[5:2]][8*wpos[1:0] +: 8] <= req_data_byte;
                  fill_ff <= wpos + 7'd1;
               end
            end
            ST_LOAD: begin
               for (int i = 0; i < 8; i++) begin
                  v_ff[i]   <= h_ff[i];
                  v_ff[i+8] <= iv_word(3'(i));
               end
               v_ff[12] <= iv_word(3'd4) ^ count_ff[31:0];
               v_ff[13] <= iv_word(3'd5) ^ count_ff[63:32];
               if (final_ff) v_ff[14] <= ~iv_word(3'd6);
               round_ff <= '0; gidx_ff <= '0; half_ff <= 1'b0;
            end
            ST_MIX: begin
               v_ff[ia] <= ga; v_ff[ib] <= gb; v_ff[ic] <= gc; v_ff[id] <= gd;
               half_ff <= !half_ff;
               if (half_ff) begin
                  gidx_ff <= gidx_ff + 3'd1;
                  if (gidx_ff == 3'd7) round_ff <= round_ff + 4'd1;
               end
               fold_ff <= '0;
            end
            ST_FOLD: begin
               h_ff[fold_ff] <= h_ff[fold_ff] ^ v_ff[fold_ff] ^ v_ff[{1'b1, fold_ff}];
               fold_ff <= fold_ff + 3'd1;
               if (fold_ff == 3'd7) begin
                  out_ff <= '0;
                  if (pend_ff) begin
                     // block was compressed; the waiting byte opens the next one
                     pend_ff <= 1'b0;
                     m_ff[0][7:0] <= pend_byte_ff;
                     fill_ff <= 7'd1;
                  end
               end
            end
            ST_EMIT: if (rsp_acc) begin
               out_ff <= out_ff + 5'd1;
               if (out_ff == 5'(act_len_ff - 6'd1)) begin
                  fresh_ff <= 1'b1;
                  fill_ff  <= 7'd0;
               end
            end
            default: ;
         endcase
      end
   end

   // responses come straight from the chain value, held while EMIT waits
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_byte = h_ff[out_ff[4:2]][8*out_ff[1:0] +: 8];
   assign rsp_byte_index  = out_ff;
   assign rsp_last        = (out_ff == 5'(act_len_ff - 6'd1));

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_emit_after_fold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_FOLD)
      else $error("response without a final compression");
   a_last_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_last) |=> !rsp_valid)
      else $error("response after last byte");
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'd64)
      else $error("fill count out of range");

endmodule
